### hdl/jfhs_pkg.sv
// Shared types and constants for the JPEG frame header scanner.
package jfhs_pkg;

  // Result status codes
  localparam logic [2:0] StFrameFound  = 3'd0;
  localparam logic [2:0] StBadSoi      = 3'd1;
  localparam logic [2:0] StNonMarker   = 3'd2;
  localparam logic [2:0] StUnsupSof    = 3'd3;
  localparam logic [2:0] StTruncated   = 3'd4;
  localparam logic [2:0] StBadLength   = 3'd5;

  // Frame modes
  localparam logic [1:0] ModeUnknown   = 2'd0;
  localparam logic [1:0] ModeBaseline  = 2'd1;
  localparam logic [1:0] ModeExtended  = 2'd2;
  localparam logic [1:0] ModeLossless  = 2'd3;

  // Marker bytes
  localparam logic [7:0] MarkerPrefix  = 8'hFF;
  localparam logic [7:0] CodeSoi       = 8'hD8;
  localparam logic [7:0] CodeSof0      = 8'hC0;
  localparam logic [7:0] CodeSof1      = 8'hC1;
  localparam logic [7:0] CodeSof2      = 8'hC2;
  localparam logic [7:0] CodeSof3      = 8'hC3;
  localparam logic [7:0] CodeDht       = 8'hC4;
  localparam logic [7:0] CodeSof5      = 8'hC5;
  localparam logic [7:0] CodeSof11     = 8'hCB;
  localparam logic [7:0] CodeDac       = 8'hCC;
  localparam logic [7:0] CodeSof13     = 8'hCD;
  localparam logic [7:0] CodeSof15     = 8'hCF;
  localparam logic [7:0] CodeSos       = 8'hDA;
  localparam logic [7:0] CodeDfLast    = 8'hDF;
  localparam logic [7:0] CodeApp0      = 8'hE0;
  localparam logic [7:0] CodeApp15     = 8'hEF;
  localparam logic [7:0] CodeCom       = 8'hFE;

  // One scan result
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  components;
    logic [15:0] cols;
    logic [15:0] rows;
    logic [7:0]  precision;
    logic [1:0]  mode;
  } jfhs_result_t;

endpackage

### hdl/jfhs_core.sv
// Byte-wise marker walker: parse state, held frame header fields and result build.
module jfhs_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_valid_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output logic                  res_valid_o,
  output jfhs_pkg::jfhs_result_t res_o
);
  import jfhs_pkg::*;

  typedef enum logic [3:0] {
    PhSoiHi, PhSoiLo, PhMarkFf, PhMarkId, PhLenHi, PhLenLo, PhSkip,
    PhFlenHi, PhFlenLo, PhPrec, PhRowsHi, PhRowsLo, PhColsHi, PhColsLo, PhNcomp
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  hi_q, hi_d;
  logic [1:0]  mode_q, mode_d;
  logic [7:0]  prec_q, prec_d;
  logic [15:0] rows_q, rows_d;
  logic [15:0] cols_q, cols_d;
  logic [7:0]  comps_q, comps_d;
  logic        done_q, done_d;

  logic        hit;
  logic [2:0]  hit_status;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;

  assign seg_len  = {hi_q, byte_i};
  assign skip_dec = skip_q - 16'd1;

  // Advance the parser by one byte
  always_comb begin
    phase_d    = phase_q;
    skip_d     = skip_q;
    hi_d       = hi_q;
    mode_d     = mode_q;
    prec_d     = prec_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    comps_d    = comps_q;
    done_d     = done_q;
    hit        = 1'b0;
    hit_status = StFrameFound;

    if (!done_q) begin
      case (phase_q)
        PhSoiHi: begin
          hi_d    = byte_i;
          phase_d = PhSoiLo;
        end
        PhSoiLo: begin
          if (hi_q != MarkerPrefix || byte_i != CodeSoi) begin
            hit        = 1'b1;
            hit_status = StBadSoi;
          end else begin
            phase_d = PhMarkFf;
          end
        end
        PhMarkId: begin
          if (byte_i == CodeSof0 || byte_i == CodeSof1 || byte_i == CodeSof3) begin
            mode_d  = (byte_i == CodeSof0) ? ModeBaseline :
                      (byte_i == CodeSof1) ? ModeExtended : ModeLossless;
            phase_d = PhFlenHi;
          end else if (byte_i == CodeSof2 ||
                       (byte_i >= CodeSof5 && byte_i <= CodeSof11) ||
                       (byte_i >= CodeSof13 && byte_i <= CodeSof15)) begin
            hit        = 1'b1;
            hit_status = StUnsupSof;
          end else if (byte_i == CodeDht || byte_i == CodeDac || byte_i == CodeCom ||
                       (byte_i >= CodeSos && byte_i <= CodeDfLast) ||
                       (byte_i >= CodeApp0 && byte_i <= CodeApp15)) begin
            phase_d = PhLenHi;
          end else begin
            phase_d = PhMarkFf;
          end
        end
        PhLenHi: begin
          hi_d    = byte_i;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          if (seg_len < 16'd2) begin
            hit        = 1'b1;
            hit_status = StBadLength;
          end else begin
            skip_d  = seg_len - 16'd2;
            phase_d = (seg_len == 16'd2) ? PhMarkFf : PhSkip;
          end
        end
        PhSkip: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            phase_d = PhMarkFf;
          end
        end
        PhFlenHi: phase_d = PhFlenLo;
        PhFlenLo: phase_d = PhPrec;
        PhPrec: begin
          prec_d  = byte_i;
          phase_d = PhRowsHi;
        end
        PhRowsHi: begin
          hi_d    = byte_i;
          phase_d = PhRowsLo;
        end
        PhRowsLo: begin
          rows_d  = {hi_q, byte_i};
          phase_d = PhColsHi;
        end
        PhColsHi: begin
          hi_d    = byte_i;
          phase_d = PhColsLo;
        end
        PhColsLo: begin
          cols_d  = {hi_q, byte_i};
          phase_d = PhNcomp;
        end
        PhNcomp: begin
          comps_d = byte_i;
          phase_d = PhMarkFf;
          if (prec_q != 8'd0) begin
            hit        = 1'b1;
            hit_status = StFrameFound;
          end
        end
        default: begin
          // expect the marker prefix byte
          if (byte_i != MarkerPrefix) begin
            hit        = 1'b1;
            hit_status = StNonMarker;
          end else begin
            phase_d = PhMarkId;
          end
        end
      endcase

      if (hit) begin
        done_d = 1'b1;
      end else if (last_i) begin
        hit        = 1'b1;
        hit_status = StTruncated;
      end
    end
  end

  // Result carries the held fields as updated by this byte
  assign res_valid_o      = hit;
  assign res_o.status     = hit_status;
  assign res_o.mode       = mode_d;
  assign res_o.precision  = prec_d;
  assign res_o.rows       = rows_d;
  assign res_o.cols       = cols_d;
  assign res_o.components = comps_d;

  // Hold parse state; re-arm after the last beat of a stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSoiHi;
      skip_q  <= '0;
      hi_q    <= '0;
      mode_q  <= ModeUnknown;
      prec_q  <= '0;
      rows_q  <= '0;
      cols_q  <= '0;
      comps_q <= '0;
      done_q  <= 1'b0;
    end else if (byte_valid_i) begin
      if (last_i) begin
        phase_q <= PhSoiHi;
        skip_q  <= '0;
        hi_q    <= '0;
        mode_q  <= ModeUnknown;
        prec_q  <= '0;
        rows_q  <= '0;
        cols_q  <= '0;
        comps_q <= '0;
        done_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        skip_q  <= skip_d;
        hi_q    <= hi_d;
        mode_q  <= mode_d;
        prec_q  <= prec_d;
        rows_q  <= rows_d;
        cols_q  <= cols_d;
        comps_q <= comps_d;
        done_q  <= done_d;
      end
    end
  end

endmodule

### hdl/jpeg_frame_header_scanner_unit.sv
// JPEG frame header scanner: one stream byte per beat in, at most one result per byte out.
// The parse step is a single pass into the result register, so a result appears on the
// master side in the cycle after its byte; one byte per cycle is taken between stalls.
// The slave side stalls only while the result register holds a beat the sink has not taken.
// Reset (async, active low) re-arms the parser to expect the first SOI byte and empties
// the result register; the parser also re-arms after every beat that carries tlast.
module jpeg_frame_header_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [1:0] frame_mode, [9:2] sample_precision,
                                      // [25:10] image_rows, [41:26] image_cols,
                                      // [49:42] component_count, [55:50] zero
  output logic [2:0]  m_axis_tuser    // [2:0] scan_status
);
  import jfhs_pkg::*;

  logic         in_fire;
  logic         res_valid;
  jfhs_result_t res;
  logic         out_valid_q;
  jfhs_result_t out_q;

  // Accept a byte whenever the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  jfhs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_fire),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Hold the result beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.components, out_q.cols, out_q.rows,
                          out_q.precision, out_q.mode};
  assign m_axis_tuser  = out_q.status;

endmodule
